/* hw/rtl/ictf_pkg.sv */
// shared types, constants and a helper function for the tilt filter
`timescale 1ns / 1ps
package ictf_pkg;

  // register indexes
  localparam logic [1:0] RegMinInterval = 2'd0;
  localparam logic [1:0] RegGyroWeight  = 2'd1;
  localparam logic [1:0] RegCalibCount  = 2'd2;

  localparam int CfgWidth = 16;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [31:0] atan_q24(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd754974720;  5'd1: r = 32'd445687602;
      5'd2: r = 32'd235489088;  5'd3: r = 32'd119537938;
      5'd4: r = 32'd60000934;   5'd5: r = 32'd30029717;
      5'd6: r = 32'd15018523;   5'd7: r = 32'd7509720;
      5'd8: r = 32'd3754917;    5'd9: r = 32'd1877466;
      5'd10: r = 32'd938734;    5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;    5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;     5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;     5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;       5'd21: r = 32'd458;
      5'd22: r = 32'd229;       5'd23: r = 32'd115;
      5'd24: r = 32'd57;        5'd25: r = 32'd29;
      5'd26: r = 32'd14;        5'd27: r = 32'd7;
      5'd28: r = 32'd4;         5'd29: r = 32'd2;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  typedef enum logic [3:0] {
    StIdle, StCalDiv, StCalDone, StSqrt, StCordic, StRate, StInc, StBlend, StOut
  } state_e;

  typedef struct packed {
    logic [31:0] angle_x;
    logic [31:0] angle_y;
    logic [31:0] angle_z;
    logic        updated;
    logic        calib_done;
  } result_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] acc_x;
    logic [15:0] acc_y;
    logic [15:0] acc_z;
    logic [15:0] rate_x;
    logic [15:0] rate_y;
    logic [15:0] rate_z;
    logic [31:0] now_ms;
  } sample_t;

endpackage

/* hw/rtl/ictf_stream_if.sv */
// valid/ready channel carrying one word
`timescale 1ns / 1ps
interface ictf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ictf_divider.sv */
// restoring serial divider, one quotient bit per cycle, signed rounded to nearest
`timescale 1ns / 1ps
module ictf_divider import ictf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic        [31:0] den_i,
  output logic               busy_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;
  logic [63:0] mag;

  // |n| + d/2 then shift-subtract
  always_comb begin
    mag   = num_i[63] ? (64'd0 - num_i) : num_i;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    trial = '0;
    if (start_i) begin
      quo_d = mag + {33'd0, den_i[31:1]};
      rem_d = '0;
      den_d = den_i;
      neg_d = num_i[63];
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      trial = {rem_q, quo_q[63]} - {33'd0, den_q};
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = start_i || (cnt_q != 7'd0);
  assign quo_o  = neg_q ? (64'd0 - quo_q) : quo_q;
endmodule

/* hw/rtl/ictf_tilt.sv */
// accelerometer tilt: serial square root then serial cordic atan2
`timescale 1ns / 1ps
module ictf_tilt import ictf_pkg::*; #(
  parameter int CordicSteps   = 16,
  parameter int AngleFracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] num_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  output logic               busy_o,
  output logic signed [31:0] tilt_o
);
  localparam int Shift = 24 - AngleFracBits;

  logic [1:0]  ph_q, ph_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic signed [47:0] x_q, x_d, y_q, y_d;
  logic signed [47:0] z_q, z_d;
  logic signed [31:0] sq_a, sq_b;
  logic [31:0] sq_sum;
  logic [47:0] rb;
  logic signed [47:0] zr;

  // phase 0 idle, 1 root, 2 cordic
  always_comb begin
    sq_a   = a_i * a_i;
    sq_b   = b_i * b_i;
    sq_sum = 32'(sq_a) + 32'(sq_b);
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    rb     = res_q + bit_q;
    if (start_i) begin
      ph_d  = 2'd1;
      v_d   = {sq_sum, 16'd0};
      res_d = '0;
      bit_d = 48'd1 << 46;
      y_d   = 48'(signed'(num_i)) <<< 8;
      z_d   = '0;
      cnt_d = '0;
    end else if (ph_q == 2'd1) begin
      if (v_q >= rb) begin
        v_d   = v_q - rb;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        ph_d = 2'd2;
        x_d  = (v_q >= rb) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
        if (((v_q >= rb) ? ((res_q >> 1) + bit_q) : (res_q >> 1)) == 48'd0 &&
            y_q == 48'sd0) begin
          ph_d = 2'd0;
        end
      end
    end else if (ph_q == 2'd2) begin
      if (!y_q[47]) begin
        x_d = x_q + (y_q >>> cnt_q);
        y_d = y_q - (x_q >>> cnt_q);
        z_d = z_q + 48'(atan_q24(cnt_q[4:0]));
      end else begin
        x_d = x_q - (y_q >>> cnt_q);
        y_d = y_q + (x_q >>> cnt_q);
        z_d = z_q - 48'(atan_q24(cnt_q[4:0]));
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(CordicSteps - 1)) begin
        ph_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  // round half up to the output fraction
  always_comb begin
    if (Shift > 0) begin
      zr = (z_q + (48'sd1 <<< (Shift > 0 ? Shift - 1 : 0))) >>> Shift;
    end else begin
      zr = z_q;
    end
  end

  assign busy_o = start_i || (ph_q != 2'd0);
  assign tilt_o = zr[31:0];
endmodule

/* hw/rtl/imu_complementary_tilt_filter_core.sv */
// top level: calibration, timing gate, tilt units and complementary filter
//  channel | dir | payload
//  in_s    | in  | cmd, acc_x/y/z, rate_x/y/z, now_ms
//  out_s   | out | angle_x/y/z, updated, calib_done
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// one word at a time; a measurement takes a start step, the serial root and cordic, then
// eight serial divisions (three rates, three increments, two blends); a calibration word
// that completes takes three divisions; any other word goes straight to the output step.
// reset is asynchronous, active low. a result waiting at the output holds the core in
// its output step; the next word is still taken while one result waits.
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_core import ictf_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ictf_stream_if.sink         in_s,
  ictf_stream_if.source       out_s,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);
  state_e st_q, st_d;
  sample_t smp_q;
  logic [7:0]  min_iv_q;
  logic [15:0] weight_q, calib_n_q, cnt_q;
  logic signed [33:0] sum_q [3];
  logic signed [25:0] off_q [3];
  logic signed [31:0] ang_q [3];
  logic [31:0] last_q;
  logic signed [63:0] tmp_q [3];
  logic [1:0]  k_q;
  logic        busy_div_q, out_v_q;
  logic        upd_q, done_q;
  result_t     res_q;

  logic        div_start, div_busy, t_start, tx_busy, ty_busy;
  logic signed [63:0] div_num, div_quo;
  logic [31:0] div_den, dt;
  logic signed [31:0] tilt_x, tilt_y;
  logic [15:0] cnt_inc, limit;
  logic signed [33:0] nsum [3];
  logic [15:0] dtc;
  logic signed [63:0] g_sat, a_plus;
  logic signed [15:0] rsel;
  logic signed [31:0] inc_rate, g_w, tilt_sel;
  logic signed [48:0] inc_prod;
  logic signed [49:0] blend_g, blend_t;

  assign in_s.ready = (st_q == StIdle);
  assign out_s.valid = out_v_q;
  assign out_s.data  = res_q;

  assign cnt_inc = cnt_q + 16'd1;
  assign limit   = (calib_n_q == 16'd0) ? 16'd1 : calib_n_q;
  assign dt      = in_s.data.now_ms - last_q;
  assign dtc     = ((smp_q.now_ms - last_q) > 32'd65535) ? 16'hFFFF
                                                         : 16'(smp_q.now_ms - last_q);
  assign nsum[0] = sum_q[0] + 34'(signed'(in_s.data.rate_x));
  assign nsum[1] = sum_q[1] + 34'(signed'(in_s.data.rate_y));
  assign nsum[2] = sum_q[2] + 34'(signed'(in_s.data.rate_z));

  ictf_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  assign t_start = (st_q == StSqrt) && !busy_div_q;
  ictf_tilt #(.CordicSteps(CORDIC_STEPS), .AngleFracBits(ANGLE_FRAC_BITS)) u_tx (
    .clk_i, .rst_ni, .start_i(t_start), .num_i(17'(signed'(smp_q.acc_y))),
    .a_i(smp_q.acc_x), .b_i(smp_q.acc_z), .busy_o(tx_busy), .tilt_o(tilt_x)
  );
  ictf_tilt #(.CordicSteps(CORDIC_STEPS), .AngleFracBits(ANGLE_FRAC_BITS)) u_ty (
    .clk_i, .rst_ni, .start_i(t_start), .num_i(-17'(signed'(smp_q.acc_x))),
    .a_i(smp_q.acc_y), .b_i(smp_q.acc_z), .busy_o(ty_busy), .tilt_o(tilt_y)
  );

  // gyro raw of the lane in work
  always_comb begin
    case (k_q)
      2'd0:    rsel = smp_q.rate_x;
      2'd1:    rsel = smp_q.rate_y;
      default: rsel = smp_q.rate_z;
    endcase
  end

  // saturated gyro prediction for the blend
  always_comb begin
    a_plus = 64'(ang_q[k_q]) + tmp_q[k_q];
    if (a_plus > 64'sd2147483647)       g_sat = 64'sd2147483647;
    else if (a_plus < -64'sd2147483648) g_sat = -64'sd2147483648;
    else                                g_sat = a_plus;
  end

  // narrow products for increment and blend
  assign inc_rate = tmp_q[k_q][31:0];
  assign g_w      = g_sat[31:0];
  assign tilt_sel = (k_q == 2'd0) ? tilt_x : tilt_y;
  assign inc_prod = inc_rate * $signed({1'b0, dtc});
  assign blend_g  = g_w * $signed({2'b0, weight_q});
  assign blend_t  = tilt_sel * $signed(18'h10000 - {2'b0, weight_q});

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 32'd1;
    if (!busy_div_q) begin
      case (st_q)
        StCalDiv: begin
          div_start = 1'b1;
          div_num   = -(64'(sum_q[k_q]) <<< 8);
          div_den   = {16'd0, cnt_q};
        end
        StRate: begin
          div_start = 1'b1;
          div_num   = ((64'(rsel) <<< 8) + 64'(off_q[k_q])) <<< ANGLE_FRAC_BITS;
          div_den   = 32'd33536;
        end
        StInc: begin
          div_start = 1'b1;
          div_num   = 64'(inc_prod);
          div_den   = 32'd1000;
        end
        StBlend: begin
          div_start = 1'b1;
          div_num   = 64'(blend_g) + 64'(blend_t);
          div_den   = 32'd65536;
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (in_s.valid && in_s.ready) begin
          if (!in_s.data.cmd) begin
            st_d = (cnt_inc >= limit) ? StCalDiv : StOut;
          end else begin
            st_d = (dt >= {24'd0, min_iv_q}) ? StSqrt : StOut;
          end
        end
      end
      StCalDiv:  if (busy_div_q && !div_busy && k_q == 2'd2) st_d = StCalDone;
      StCalDone: st_d = StOut;
      StSqrt:    st_d = StCordic;
      StCordic:  if (!tx_busy && !ty_busy) st_d = StRate;
      StRate:    if (busy_div_q && !div_busy) st_d = StInc;
      StInc: begin
        if (busy_div_q && !div_busy) st_d = (k_q == 2'd2) ? StOut : StRate;
        if (busy_div_q && !div_busy && k_q == 2'd2) st_d = StBlend;
      end
      StBlend:   if (busy_div_q && !div_busy && k_q == 2'd1) st_d = StOut;
      StOut:     if (!out_v_q || out_s.ready) st_d = StIdle;
      default:   st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      min_iv_q  <= 8'd3;
      weight_q  <= 16'd64225;
      calib_n_q <= 16'd100;
      cnt_q     <= '0;
      last_q    <= '0;
      out_v_q   <= 1'b0;
      busy_div_q <= 1'b0;
      k_q       <= '0;
      upd_q     <= 1'b0;
      done_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        off_q[i] <= '0;
        ang_q[i] <= '0;
      end
      res_q     <= '0;
    end else begin
      st_q <= st_d;
      // config writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMinInterval: min_iv_q  <= cfg_data_i[7:0];
          RegGyroWeight:  weight_q  <= cfg_data_i;
          RegCalibCount:  calib_n_q <= cfg_data_i;
          default: ;
        endcase
      end
      // output word valid
      if (st_q == StOut && (!out_v_q || out_s.ready)) out_v_q <= 1'b1;
      else if (out_v_q && out_s.ready) out_v_q <= 1'b0;
      if (div_start) busy_div_q <= 1'b1;
      else if (busy_div_q && !div_busy) busy_div_q <= 1'b0;
      // per-state work
      case (st_q)
        StIdle: begin
          k_q <= '0;
          if (in_s.valid && in_s.ready) begin
            upd_q  <= 1'b0;
            done_q <= 1'b0;
            if (!in_s.data.cmd) begin
              cnt_q <= cnt_inc;
              for (int i = 0; i < 3; i++) sum_q[i] <= nsum[i];
            end
          end
        end
        StCalDiv: begin
          if (busy_div_q && !div_busy) begin
            off_q[k_q] <= div_quo[25:0];
            k_q <= k_q + 2'd1;
          end
        end
        StCalDone: begin
          cnt_q <= '0;
          for (int i = 0; i < 3; i++) sum_q[i] <= '0;
          done_q <= 1'b1;
        end
        StRate: begin
          if (busy_div_q && !div_busy) tmp_q[k_q] <= div_quo;
        end
        StInc: begin
          if (busy_div_q && !div_busy) begin
            tmp_q[k_q] <= div_quo;
            k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
            if (k_q == 2'd2) ang_q[2] <= ang_q[2] + div_quo[31:0];
          end
        end
        StBlend: begin
          if (busy_div_q && !div_busy) begin
            ang_q[k_q] <= div_quo[31:0];
            k_q <= k_q + 2'd1;
            if (k_q == 2'd1) begin
              last_q <= smp_q.now_ms;
              upd_q  <= 1'b1;
            end
          end
        end
        StOut: begin
          if (!out_v_q || out_s.ready) begin
            res_q.angle_x    <= ang_q[0];
            res_q.angle_y    <= ang_q[1];
            res_q.angle_z    <= ang_q[2];
            res_q.updated    <= upd_q;
            res_q.calib_done <= done_q;
          end
        end
        default: ;
      endcase
    end
  end

  // captured input word
  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) smp_q <= in_s.data;
  end
endmodule
